>>> rtl/core/http_response_deframer_unit_defines.svh
// Assertion macros for the HTTP response deframer.
// Included by the top level; expects a clock named clk and a reset named arst_n.
`ifndef HTTP_RESPONSE_DEFRAMER_UNIT_DEFINES_SVH
`define HTTP_RESPONSE_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define HRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define HRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/hrd_pkg.sv
// Shared types, phase codes, framing constants and byte helpers for the
// HTTP response deframer. No dependencies.
package hrd_pkg;

	typedef logic [7:0] byte_t;
	typedef logic [2:0] phase_t;
	typedef logic [9:0] status_t;
	typedef logic [1:0] err_t;

	localparam phase_t PH_STATUS   = 3'd0;
	localparam phase_t PH_HEADERS  = 3'd1;
	localparam phase_t PH_CHUNKLEN = 3'd2;
	localparam phase_t PH_CHUNKEND = 3'd3;
	localparam phase_t PH_BODY     = 3'd4;
	localparam phase_t PH_TRAILERS = 3'd5;
	localparam phase_t PH_COMPLETE = 3'd6;

	localparam err_t ERR_NONE      = 2'd0;
	localparam err_t ERR_NO_LENGTH = 2'd1;
	localparam err_t ERR_SATURATED = 2'd2;

	// Candidate bits of the header name matcher
	localparam int CAND_CL = 0;
	localparam int CAND_TE = 1;

	localparam int ClLen      = 14;
	localparam int TeLen      = 17;
	localparam int ChunkedLen = 7;
	localparam logic [4:0] NAME_POS_MAX = 5'd31;
	localparam status_t STATUS_CONTINUE = 10'd100;
	localparam status_t STATUS_INFO_LO  = 10'd100;
	localparam status_t STATUS_INFO_HI  = 10'd200;

	localparam byte_t CH_LF    = 8'h0A;
	localparam byte_t CH_CR    = 8'h0D;
	localparam byte_t CH_COLON = 8'h3A;

	localparam logic [8*ClLen-1:0]      ClText      = "content-length";
	localparam logic [8*TeLen-1:0]      TeText      = "transfer-encoding";
	localparam logic [8*ChunkedLen-1:0] ChunkedText = "chunked";

	function automatic logic is_ws(input byte_t c);
		return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	endfunction

	function automatic logic is_digit(input byte_t c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic byte_t to_lower(input byte_t c);
		return (c inside {[8'h41:8'h5A]}) ? byte_t'(c + 8'h20) : c;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(input byte_t c);
		byte_t lc;
		lc = to_lower(c);
		if (is_digit(c))
			return {1'b1, c[3:0]};
		else if (lc inside {[8'h61:8'h66]})
			return {1'b1, 4'(lc[3:0] + 4'd9)};
		else
			return 5'd0;
	endfunction

	function automatic byte_t cl_char(input logic [4:0] pos);
		int idx;
		idx = ClLen - 1 - int'(pos);
		if (int'(pos) >= ClLen)
			return 8'h00;
		return ClText[8*idx +: 8];
	endfunction

	function automatic byte_t te_char(input logic [4:0] pos);
		int idx;
		idx = TeLen - 1 - int'(pos);
		if (int'(pos) >= TeLen)
			return 8'h00;
		return TeText[8*idx +: 8];
	endfunction

	function automatic byte_t chunked_char(input logic [4:0] pos);
		int idx;
		idx = ChunkedLen - 1 - int'(pos);
		if (int'(pos) >= ChunkedLen)
			return 8'h00;
		return ChunkedText[8*idx +: 8];
	endfunction

	function automatic err_t err_max(input err_t a, input err_t b);
		return (b > a) ? b : a;
	endfunction

endpackage

>>> rtl/core/hrd_stream_if.sv
// Valid/ready channel interfaces of the HTTP response deframer.
// Depends on hrd_pkg for the payload types.
interface hrd_in_if import hrd_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t byte_in;
	logic  start_req;

	modport source (output valid, byte_in, start_req, input ready);
	modport sink   (input valid, byte_in, start_req, output ready);
endinterface

interface hrd_out_if import hrd_pkg::*; ();
	logic    valid;
	logic    ready;
	logic    body_valid;
	byte_t   body_byte;
	phase_t  phase;
	status_t http_status;
	err_t    error_code;

	modport source (output valid, body_valid, body_byte, phase, http_status, error_code,
		input ready);
	modport sink   (input valid, body_valid, body_byte, phase, http_status, error_code,
		output ready);
endinterface

>>> rtl/core/http_response_deframer_unit.sv
// Channel   | dir | payload
// stream    | in  | byte_in[7:0], start_req
// result    | out | body_valid, body_byte[7:0], phase[2:0], http_status[9:0], error_code[1:0]
//
// One result per request; a request enters every cycle while the result is not
// stalled. A request passes the input register, then the parser state and result
// register, which update together.
// arst_n clears the parser to the status-line phase and empties both registers.
// A stalled result holds; the input register still takes one more request.
// Depends on hrd_pkg, hrd_stream_if and the defines header.
`include "http_response_deframer_unit_defines.svh"

module http_response_deframer_unit import hrd_pkg::*; #(
	parameter int LEN_BITS = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	hrd_in_if.sink             stream,
	hrd_out_if.source          result
);

	localparam logic [LEN_BITS-1:0] LenMax = '1;

	// input stage
	logic  valid_s1;
	byte_t byte_s1;
	logic  start_s1;

	// parser state
	phase_t              phase_q;
	status_t             status_q;
	logic [1:0]          sline_step_q;
	logic                chunked_mode_q;
	logic [LEN_BITS-1:0] bytes_left_q;
	logic [4:0]          name_pos_q;
	logic [1:0]          cand_q;
	logic [1:0]          value_step_q;
	logic [LEN_BITS-1:0] length_q;
	logic                length_seen_q;
	logic                chunked_seen_q;
	logic                line_empty_q;
	err_t                err_q;

	// result register
	logic    out_valid_q;
	logic    body_valid_q;
	byte_t   body_byte_q;
	phase_t  phase_out_q;
	status_t status_out_q;
	err_t    err_out_q;

	logic advance;
	logic fire;

	// next-state values
	phase_t              nx_phase;
	status_t             nx_status;
	logic [1:0]          nx_sline;
	logic                nx_cmode;
	logic [LEN_BITS-1:0] nx_left;
	logic [4:0]          nx_pos;
	logic [1:0]          nx_cand;
	logic [1:0]          nx_vstep;
	logic [LEN_BITS-1:0] nx_len;
	logic                nx_lseen;
	logic                nx_cseen;
	logic                nx_lempty;
	err_t                nx_err;
	logic                nx_bvalid;

	assign advance      = !out_valid_q || result.ready;
	assign fire         = valid_s1 && advance;
	assign stream.ready = !valid_s1 || advance;

	always_comb begin
		phase_t              ph;
		status_t             sv;
		logic [1:0]          sls;
		logic                cm;
		logic [LEN_BITS-1:0] bl;
		logic [4:0]          np;
		logic [1:0]          cand;
		logic [1:0]          vs;
		logic [LEN_BITS-1:0] lv;
		logic                ls;
		logic                cs;
		logic                le;
		err_t                ef;
		byte_t               c;
		byte_t               lc;
		logic                ws;
		logic [1:0]          fl_cand;
		logic                fl_ls;
		logic                fl_cs;
		logic [LEN_BITS-1:0] fl_bl;
		logic [1:0]          closed;
		logic [LEN_BITS+3:0] prod10;
		logic [LEN_BITS-1:0] sum16;
		logic                ovf16;
		logic [4:0]          hv;
		logic                do_digit;
		logic                in_value;

		c  = byte_s1;
		lc = to_lower(byte_s1);
		ws = is_ws(byte_s1);
		hv = hex_val(byte_s1);

		// a start request restarts the parser before this byte
		if (start_s1) begin
			ph = PH_STATUS; sv = '0; sls = '0; cm = 1'b0; bl = '0; np = '0;
			cand = 2'b11; vs = '0; lv = '0; ls = 1'b0; cs = 1'b0; le = 1'b1;
			ef = ERR_NONE;
		end else begin
			ph = phase_q; sv = status_q; sls = sline_step_q; cm = chunked_mode_q;
			bl = bytes_left_q; np = name_pos_q; cand = cand_q; vs = value_step_q;
			lv = length_q; ls = length_seen_q; cs = chunked_seen_q; le = line_empty_q;
			ef = err_q;
		end

		// header flush as seen from the state before this byte
		closed = cand;
		if (np != 5'(ClLen)) closed[CAND_CL] = 1'b0;
		if (np != 5'(TeLen)) closed[CAND_TE] = 1'b0;
		fl_cand = (vs == 2'd0) ? closed : cand;
		fl_bl   = fl_cand[CAND_CL] ? lv : bl;
		fl_ls   = fl_cand[CAND_CL] ? 1'b1 : ls;
		fl_cs   = fl_cand[CAND_TE] ? (vs == 2'd2 && np == 5'(ChunkedLen)) : cs;

		// hex accumulate (chunk length line)
		ovf16 = (lv[LEN_BITS-1 -: 4] != 4'd0);
		sum16 = {lv[LEN_BITS-5:0], hv[3:0]};

		nx_phase = ph; nx_status = sv; nx_sline = sls; nx_cmode = cm; nx_left = bl;
		nx_pos = np; nx_cand = cand; nx_vstep = vs; nx_len = lv; nx_lseen = ls;
		nx_cseen = cs; nx_lempty = le; nx_err = ef; nx_bvalid = 1'b0;
		prod10 = '0;
		do_digit = 1'b0;
		in_value = 1'b0;

		if (ph == PH_BODY) begin
			if (bl != '0) begin
				nx_bvalid = 1'b1;
				nx_left   = bl - LEN_BITS'(1);
			end
			if (nx_left == '0)
				nx_phase = cm ? PH_CHUNKEND : PH_TRAILERS;
		end else if (ph != PH_COMPLETE) begin
			if (c == CH_LF) begin
				nx_lempty = 1'b1;
				case (ph)
					PH_STATUS: begin
						nx_phase = PH_HEADERS;
						nx_cand = 2'b11; nx_pos = '0; nx_vstep = '0; nx_len = '0;
					end
					PH_HEADERS: begin
						if (le) begin
							nx_left = fl_bl; nx_lseen = fl_ls; nx_cseen = fl_cs;
							nx_cand = 2'b11; nx_pos = '0; nx_vstep = '0; nx_len = '0;
							if (sv == STATUS_CONTINUE) begin
								nx_phase = PH_STATUS; nx_status = '0; nx_sline = '0;
							end else if (sv >= STATUS_INFO_LO && sv < STATUS_INFO_HI) begin
								nx_phase = PH_TRAILERS;
							end else if (fl_cs) begin
								nx_cmode = 1'b1;
								nx_phase = PH_CHUNKLEN;
							end else if (fl_ls) begin
								nx_phase = (fl_bl != '0) ? PH_BODY : PH_TRAILERS;
							end else begin
								nx_err   = err_max(ef, ERR_NO_LENGTH);
								nx_phase = PH_COMPLETE;
							end
						end
					end
					PH_CHUNKLEN: begin
						nx_left  = lv;
						nx_cand = 2'b11; nx_pos = '0; nx_vstep = '0; nx_len = '0;
						nx_phase = (lv != '0) ? PH_BODY : PH_TRAILERS;
					end
					PH_CHUNKEND: begin
						nx_cand = 2'b11; nx_pos = '0; nx_vstep = '0; nx_len = '0;
						nx_phase = PH_CHUNKLEN;
					end
					PH_TRAILERS: nx_phase = PH_COMPLETE;
					default: ;
				endcase
			end else if (c != CH_CR) begin
				nx_lempty = 1'b0;
				case (ph)
					PH_STATUS: begin
						case (sls)
							2'd0: if (!ws) nx_sline = 2'd1;
							2'd1: if (ws) nx_sline = 2'd2;
							2'd2: if (!ws) begin
								nx_sline = 2'd3;
								do_digit = 1'b1;
							end
							default: do_digit = 1'b1;
						endcase
						if (do_digit) begin
							if (np < 5'd3 && is_digit(c)) begin
								nx_status = 10'({sv[6:0], 3'b0} + {sv[8:0], 1'b0}
									+ {6'd0, c[3:0]});
								nx_pos = 5'(np + 5'd1);
							end else begin
								nx_pos = 5'd3;
							end
						end
					end
					PH_HEADERS: begin
						// a new header line commits the previous one
						if (le && !ws) begin
							nx_left = fl_bl; nx_lseen = fl_ls; nx_cseen = fl_cs;
							np = '0; cand = 2'b11; vs = '0; lv = '0;
							nx_pos = np; nx_cand = cand; nx_vstep = vs; nx_len = lv;
						end
						if (vs == 2'd0) begin
							if (c == CH_COLON) begin
								closed = cand;
								if (np != 5'(ClLen)) closed[CAND_CL] = 1'b0;
								if (np != 5'(TeLen)) closed[CAND_TE] = 1'b0;
								nx_cand  = closed;
								nx_pos   = '0;
								nx_vstep = (closed != 2'b00) ? 2'd1 : 2'd3;
							end else begin
								if (!(np < 5'(ClLen) && lc == cl_char(np)))
									nx_cand[CAND_CL] = 1'b0;
								if (!(np < 5'(TeLen) && lc == te_char(np)))
									nx_cand[CAND_TE] = 1'b0;
								if (np < NAME_POS_MAX) nx_pos = 5'(np + 5'd1);
							end
						end else if (vs == 2'd1) begin
							if (!ws) begin
								nx_vstep = 2'd2;
								in_value = 1'b1;
							end
						end else if (vs == 2'd2) begin
							in_value = 1'b1;
						end
						if (in_value) begin
							if (cand[CAND_CL]) begin
								if (is_digit(c)) begin
									prod10 = {1'b0, lv, 3'b0} + {3'b0, lv, 1'b0}
										+ {{(LEN_BITS){1'b0}}, c[3:0]};
									if (prod10[LEN_BITS+3:LEN_BITS] != 4'd0) begin
										nx_err = err_max(ef, ERR_SATURATED);
										nx_len = LenMax;
									end else begin
										nx_len = prod10[LEN_BITS-1:0];
									end
								end else begin
									nx_vstep = 2'd3;
								end
							end else if (cand[CAND_TE]) begin
								if (np < 5'(ChunkedLen) && lc == chunked_char(np))
									nx_pos = 5'(np + 5'd1);
								else
									nx_vstep = 2'd3;
							end else begin
								nx_vstep = 2'd3;
							end
						end
					end
					PH_CHUNKLEN: begin
						if (!(vs == 2'd0 && ws)) begin
							if (vs <= 2'd1 && hv[4]) begin
								nx_vstep = 2'd1;
								if (ovf16) begin
									nx_err = err_max(ef, ERR_SATURATED);
									nx_len = LenMax;
								end else begin
									nx_len = sum16;
								end
							end else begin
								nx_vstep = 2'd3;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1  <= stream.byte_in;
			start_s1 <= stream.start_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_STATUS;
			status_q       <= '0;
			sline_step_q   <= '0;
			chunked_mode_q <= 1'b0;
			bytes_left_q   <= '0;
			name_pos_q     <= '0;
			cand_q         <= 2'b11;
			value_step_q   <= '0;
			length_q       <= '0;
			length_seen_q  <= 1'b0;
			chunked_seen_q <= 1'b0;
			line_empty_q   <= 1'b1;
			err_q          <= ERR_NONE;
		end else if (fire) begin
			phase_q        <= nx_phase;
			status_q       <= nx_status;
			sline_step_q   <= nx_sline;
			chunked_mode_q <= nx_cmode;
			bytes_left_q   <= nx_left;
			name_pos_q     <= nx_pos;
			cand_q         <= nx_cand;
			value_step_q   <= nx_vstep;
			length_q       <= nx_len;
			length_seen_q  <= nx_lseen;
			chunked_seen_q <= nx_cseen;
			line_empty_q   <= nx_lempty;
			err_q          <= nx_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			body_valid_q <= nx_bvalid;
			body_byte_q  <= nx_bvalid ? byte_s1 : 8'h00;
			phase_out_q  <= nx_phase;
			status_out_q <= nx_status;
			err_out_q    <= nx_err;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.body_valid  = body_valid_q;
	assign result.body_byte   = body_byte_q;
	assign result.phase       = phase_out_q;
	assign result.http_status = status_out_q;
	assign result.error_code  = err_out_q;

	`HRD_ASSERT_NEXT(a_fire_loads_result, fire, out_valid_q, "processed request lost its result")
	`HRD_ASSERT_NEXT(a_body_only_in_body, fire && !start_s1 && phase_q != PH_BODY, !body_valid_q, "body byte outside body phase")
	`HRD_ASSERT_NEXT(a_error_monotonic, fire && !start_s1, err_q >= $past(err_q), "error code dropped without restart")
	`HRD_ASSERT_NOW(a_chunkend_needs_mode, phase_q == PH_CHUNKEND, chunked_mode_q, "chunk end outside chunked framing")

endmodule

>>> tb/tb.sv
// Self-checking bench for http_response_deframer_unit: random HTTP responses go in
// byte by byte, and every result is checked against a predictor kept in step.
// Depends on hrd_pkg and the hrd_in_if / hrd_out_if channel interfaces.
module tb;
	import hrd_pkg::*;

	localparam int LenBits = 32;
	localparam logic [63:0] LenMax = {64{1'b1}} >> (64 - LenBits);
	localparam int WatchdogLimit = 2000;
	localparam int LongHold = 80;

	localparam string ClName = "content-length";
	localparam string TeName = "transfer-encoding";
	localparam string ChunkedName = "chunked";
	localparam int ClNameLen = 14;
	localparam int TeNameLen = 17;
	localparam int ChunkedNameLen = 7;

	typedef struct packed {
		logic    body_valid;
		byte_t   body_byte;
		phase_t  phase;
		status_t http_status;
		err_t    error_code;
	} deframe_out_t;

	class response_checker;
		phase_t      ph;
		int unsigned status;
		int          status_step;
		bit          chunked_mode;
		logic [63:0] remaining;
		int          name_pos;
		bit          cl_live;
		bit          te_live;
		int          value_step;
		logic [63:0] len_acc;
		bit          len_seen;
		bit          chunked_seen;
		bit          line_blank;
		err_t        err;
		deframe_out_t expected_q[$];
		int          fails;
		int          checked;

		function new();
			fails = 0;
			checked = 0;
			restart();
		endfunction

		function void clear_matcher();
			cl_live = 1;
			te_live = 1;
			name_pos = 0;
			value_step = 0;
			len_acc = 0;
		endfunction

		function void restart();
			ph = PH_STATUS;
			status = 0;
			status_step = 0;
			chunked_mode = 0;
			remaining = 0;
			clear_matcher();
			len_seen = 0;
			chunked_seen = 0;
			line_blank = 1;
			err = ERR_NONE;
		endfunction

		function bit is_space(byte_t c);
			return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
		endfunction

		function byte_t fold(byte_t c);
			return (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
		endfunction

		function int hex_digit(byte_t c);
			byte_t lc;
			lc = fold(c);
			if (c >= "0" && c <= "9")
				return int'(c - "0");
			if (lc >= "a" && lc <= "f")
				return int'(lc - "a") + 10;
			return -1;
		endfunction

		function void raise(err_t code);
			if (code > err)
				err = code;
		endfunction

		// Saturate at the top of the length range instead of wrapping
		function logic [63:0] accumulate(logic [63:0] v, int unsigned d, int unsigned base);
			if (v > (LenMax - d) / base) begin
				raise(ERR_SATURATED);
				return LenMax;
			end
			return v * base + d;
		endfunction

		function void name_end();
			if (name_pos != ClNameLen)
				cl_live = 0;
			if (name_pos != TeNameLen)
				te_live = 0;
		endfunction

		function void header_commit();
			if (value_step == 0)
				name_end();
			if (cl_live) begin
				remaining = len_acc;
				len_seen = 1;
			end
			if (te_live)
				chunked_seen = (value_step == 2 && name_pos == ChunkedNameLen);
		endfunction

		function void header_char(byte_t c);
			byte_t lc;
			lc = fold(c);
			if (value_step == 0) begin
				if (c == CH_COLON) begin
					name_end();
					name_pos = 0;
					value_step = (cl_live || te_live) ? 1 : 3;
					return;
				end
				if (!(name_pos < ClNameLen && lc == ClName[name_pos]))
					cl_live = 0;
				if (!(name_pos < TeNameLen && lc == TeName[name_pos]))
					te_live = 0;
				if (name_pos < 31)
					name_pos++;
				return;
			end
			if (value_step == 1) begin
				if (is_space(c))
					return;
				value_step = 2;
			end
			if (value_step != 2)
				return;
			if (cl_live) begin
				if (c >= "0" && c <= "9")
					len_acc = accumulate(len_acc, int'(c - "0"), 10);
				else
					value_step = 3;
			end else if (te_live) begin
				if (name_pos < ChunkedNameLen && lc == ChunkedName[name_pos])
					name_pos++;
				else
					value_step = 3;
			end else begin
				value_step = 3;
			end
		endfunction

		// Skip the version token, then take up to three digits of the code
		function void status_char(byte_t c);
			case (status_step)
				0: begin
					if (!is_space(c))
						status_step = 1;
					return;
				end
				1: begin
					if (is_space(c))
						status_step = 2;
					return;
				end
				2: begin
					if (is_space(c))
						return;
					status_step = 3;
				end
				default: ;
			endcase
			if (name_pos < 3 && c >= "0" && c <= "9") begin
				status = status * 10 + int'(c - "0");
				name_pos++;
			end else begin
				name_pos = 3;
			end
		endfunction

		function void chunk_len_char(byte_t c);
			int h;
			h = hex_digit(c);
			if (value_step == 0 && is_space(c))
				return;
			if (value_step <= 1 && h >= 0) begin
				value_step = 1;
				len_acc = accumulate(len_acc, h, 16);
			end else begin
				value_step = 3;
			end
		endfunction

		function void enter_body();
			if (status >= STATUS_INFO_LO && status < STATUS_INFO_HI) begin
				ph = PH_TRAILERS;
			end else if (chunked_seen) begin
				chunked_mode = 1;
				ph = PH_CHUNKLEN;
			end else if (len_seen) begin
				ph = (remaining != 0) ? PH_BODY : PH_TRAILERS;
			end else begin
				raise(ERR_NO_LENGTH);
				ph = PH_COMPLETE;
			end
		endfunction

		function void end_of_line();
			case (ph)
				PH_STATUS: begin
					ph = PH_HEADERS;
					clear_matcher();
				end
				PH_HEADERS: begin
					if (line_blank) begin
						header_commit();
						clear_matcher();
						if (status == STATUS_CONTINUE) begin
							ph = PH_STATUS;
							status = 0;
							status_step = 0;
						end else begin
							enter_body();
						end
					end
				end
				PH_CHUNKLEN: begin
					remaining = len_acc;
					clear_matcher();
					ph = (remaining != 0) ? PH_BODY : PH_TRAILERS;
				end
				PH_CHUNKEND: begin
					clear_matcher();
					ph = PH_CHUNKLEN;
				end
				PH_TRAILERS: ph = PH_COMPLETE;
				default: ;
			endcase
			line_blank = 1;
		endfunction

		function void line_char(byte_t c);
			case (ph)
				PH_STATUS: status_char(c);
				PH_HEADERS: begin
					// a line led by white space continues the previous header
					if (line_blank && !is_space(c)) begin
						header_commit();
						clear_matcher();
					end
					header_char(c);
				end
				PH_CHUNKLEN: chunk_len_char(c);
				default: ;
			endcase
			line_blank = 0;
		endfunction

		function deframe_out_t deframe_byte(byte_t c, bit start);
			deframe_out_t r;
			r.body_valid = 0;
			r.body_byte = 8'h00;
			if (start)
				restart();
			if (ph == PH_BODY) begin
				if (remaining != 0) begin
					r.body_valid = 1;
					r.body_byte = c;
					remaining--;
				end
				if (remaining == 0)
					ph = chunked_mode ? PH_CHUNKEND : PH_TRAILERS;
			end else if (ph != PH_COMPLETE) begin
				if (c == CH_LF)
					end_of_line();
				else if (c != CH_CR)
					line_char(c);
			end
			r.phase = ph;
			r.http_status = status_t'(status);
			r.error_code = err;
			return r;
		endfunction

		function void note_byte(byte_t c, bit start);
			expected_q.push_back(deframe_byte(c, start));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(deframe_out_t got);
			deframe_out_t want;
			checked++;
			if (expected_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				fails++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("body_valid", want.body_valid, got.body_valid);
			compare_field("body_byte", want.body_byte, got.body_byte);
			compare_field("phase", want.phase, got.phase);
			compare_field("http_status", want.http_status, got.http_status);
			compare_field("error_code", want.error_code, got.error_code);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   idle_cycles = 0;
	byte_t frame_bytes[$];
	response_checker tracker = new();

	hrd_in_if  in_ch ();
	hrd_out_if out_ch ();

	http_response_deframer_unit #(.LEN_BITS(LenBits)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.stream(in_ch),
		.result(out_ch)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		deframe_out_t seen;
		if (out_ch.valid && out_ch.ready) begin
			seen.body_valid = out_ch.body_valid;
			seen.body_byte = out_ch.body_byte;
			seen.phase = out_ch.phase;
			seen.http_status = out_ch.http_status;
			seen.error_code = out_ch.error_code;
			tracker.check_result(seen);
		end
		if (in_ch.valid && in_ch.ready)
			tracker.note_byte(in_ch.byte_in, in_ch.start_req);
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Mostly no gap, sometimes a short one, rarely a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			frame_bytes.push_back(s[i]);
	endfunction

	function automatic void add_eol();
		case ($urandom_range(0, 9))
			0: add_text("\n");
			1: add_text("\r\r\n");
			default: add_text("\r\n");
		endcase
	endfunction

	function automatic void add_ws(int lo, int hi);
		repeat ($urandom_range(lo, hi))
			frame_bytes.push_back(($urandom_range(0, 3) == 0) ? 8'h09 : 8'h20);
	endfunction

	function automatic void add_random(int n);
		repeat (n)
			frame_bytes.push_back(byte_t'($urandom));
	endfunction

	function automatic string mix_case(string s);
		string t;
		t = s;
		for (int i = 0; i < t.len(); i++)
			if (t[i] >= "a" && t[i] <= "z" && $urandom_range(0, 1))
				t[i] = t[i] - 8'h20;
		return t;
	endfunction

	function automatic void add_header(string name, string value);
		add_text(mix_case(name));
		add_text(":");
		add_ws(0, 2);
		add_text(value);
		add_eol();
	endfunction

	function automatic void add_status_line(string code);
		if ($urandom_range(0, 7) == 0)
			add_ws(1, 1);
		if ($urandom_range(0, 3) == 0)
			add_text("HTTP/1.1");
		else
			add_text("H");
		if (code.len() > 0) begin
			add_ws(1, 2);
			add_text(code);
			if ($urandom_range(0, 1))
				add_text(" OK");
		end
		add_eol();
	endfunction

	function automatic string pick_code();
		case ($urandom_range(0, 15))
			7: return "404";
			8: return "101";
			9: return "199";
			10: return $sformatf("%0d", $urandom_range(100, 999));
			11: return $sformatf("%0d", $urandom_range(1000, 9999));
			12: return "";
			13: return "20x";
			14: return "7";
			15: return "100";
			default: return "200";
		endcase
	endfunction

	function automatic void add_filler();
		case ($urandom_range(0, 8))
			0: add_header("a", "b");
			1: add_header("host", "x");
			2: add_header("content-lengths", "9");
			3: add_header("transfer-encoding", "gzip");
			4: add_header("transfer-encoding", "chunkedx");
			5: add_header("content-len", "3");
			6: begin
				add_text("content-length 4");
				add_eol();
			end
			7: add_header("x-padding-header-name-over-31-chars", "1");
			default: add_header("", "x");
		endcase
		// folded continuation of the header just written
		if ($urandom_range(0, 3) == 0) begin
			add_ws(1, 2);
			add_text("more");
			add_eol();
		end
	endfunction

	function automatic void add_chunk(int len);
		if ($urandom_range(0, 4) == 0)
			add_ws(1, 2);
		if ($urandom_range(0, 4) == 0)
			add_text("0");
		if ($urandom_range(0, 1))
			add_text($sformatf("%0x", len));
		else
			add_text($sformatf("%0X", len));
		if ($urandom_range(0, 4) == 0)
			add_text(";ext=1");
		add_eol();
	endfunction

	function automatic void compose_frame();
		int framing;
		int len;
		bit chunked;
		frame_bytes.delete();
		if ($urandom_range(0, 11) == 0) begin
			add_random($urandom_range(5, 20));
			return;
		end
		if ($urandom_range(0, 5) == 0) begin
			add_status_line("100");
			if ($urandom_range(0, 1))
				add_filler();
			add_eol();
		end
		add_status_line(pick_code());
		// 0-6 length, 7-12 chunked, 13-14 neither, 15-16 both, 17-19 extreme length
		framing = $urandom_range(0, 19);
		chunked = (framing >= 7 && framing <= 12) || framing == 15 || framing == 16;
		len = $urandom_range(0, 12);
		if ($urandom_range(0, 1))
			add_filler();
		if (framing <= 6 || framing == 15 || framing == 16) begin
			// earlier duplicate is overridden by the one that follows
			if ($urandom_range(0, 4) == 0)
				add_header("content-length",
					$urandom_range(0, 1) ? "+3" : $sformatf("%0d", $urandom_range(0, 99)));
			add_header("content-length", $sformatf("%0d", len));
		end
		if (chunked)
			add_header("transfer-encoding", mix_case("chunked"));
		case (framing)
			17: add_header("content-length", "4294967295");
			18: add_header("content-length",
				$urandom_range(0, 1) ? "4294967296" : "18446744073709551616");
			19: add_header("transfer-encoding", "chunked");
			default: ;
		endcase
		if ($urandom_range(0, 2) == 0)
			add_filler();
		add_eol();
		if (framing == 19) begin
			add_text($urandom_range(0, 1) ? "ffffffff" : "1ffffffff");
			add_eol();
			add_random($urandom_range(3, 6));
		end else if (framing >= 17) begin
			add_random($urandom_range(3, 6));
		end else if (chunked) begin
			repeat ($urandom_range(1, 3)) begin
				len = $urandom_range(1, 10);
				add_chunk(len);
				add_random(len);
				add_eol();
			end
			add_text("0");
			add_eol();
			if ($urandom_range(0, 2) == 0)
				add_header("t", "1");
			add_eol();
		end else if (framing >= 13) begin
			add_random($urandom_range(0, 3));
		end else begin
			add_random(len);
			if ($urandom_range(0, 1))
				add_eol();
		end
		// broken framing: cut short or one byte hit
		case ($urandom_range(0, 9))
			0: frame_bytes = frame_bytes[0:$urandom_range(0, frame_bytes.size() - 1)];
			1: frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = byte_t'($urandom);
			default: ;
		endcase
	endfunction

	// Offer each byte as one request; the first one restarts the parser
	task automatic send_frame(bit calm);
		int gap;
		for (int i = 0; i < frame_bytes.size(); i++) begin
			in_ch.valid <= 1'b1;
			in_ch.byte_in <= frame_bytes[i];
			in_ch.start_req <= (i == 0);
			do
				@(posedge clk);
			while (!in_ch.ready);
			gap = calm ? 0 : pick_gap();
			if (gap > 0) begin
				in_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		int stall;
		int calm_left;
		bit held_long;
		calm_left = 0;
		held_long = 0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = 0;
			if (calm_left > 0)
				calm_left--;
			else if ($urandom_range(0, 63) == 0)
				calm_left = $urandom_range(20, 60);
			else
				stall = pick_gap();
			// hold off long enough for the input side to back up
			if (!held_long && tracker.checked >= 150) begin
				stall = LongHold;
				held_long = 1;
			end
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		int sent;
		int frame_no;
		int useful;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.byte_in <= 8'h00;
		in_ch.start_req <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// interim 100, other 1xx into trailers, ignored bytes after completion
		frame_bytes.delete();
		add_text("A 100\n\nA 199\n\nX\n");
		frame_bytes.push_back(8'hff);
		frame_bytes.push_back(8'h00);
		send_frame(0);
		// no framing header at all
		frame_bytes.delete();
		add_text("A 204\n\n");
		send_frame(0);

		sent = 0;
		frame_no = 0;
		while (sent < 450) begin
			compose_frame();
			useful = frame_bytes.size();
			if ($urandom_range(0, 2) == 0)
				add_random($urandom_range(1, 3));
			sent += useful;
			send_frame($urandom_range(0, 3) == 0);
			frame_no++;
			// drain everything before going on
			if (frame_no == 4) begin
				in_ch.valid <= 1'b0;
				do
					@(posedge clk);
				while (tracker.pending() != 0);
			end
		end

		in_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (tracker.pending() != 0);
		repeat (8) @(posedge clk);
		if (tracker.fails == 0 && tracker.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
